// File: rtl/amr_pkg.sv
`timescale 1ns / 1ps
// Package for the reachable-ancestor minimum engine: sizes, request codes and states.
// No dependencies; used by the top-level module ancestor_min_reachability_unit.
package amr_pkg;

    localparam int MAX_NODES   = 512;
    localparam int WORD_W      = 64;
    localparam int NODE_W      = 9;
    localparam int VALUE_W     = 8;
    localparam int ROW_WORDS   = (MAX_NODES + WORD_W - 1) / WORD_W;
    localparam int WSEL_W      = $clog2(ROW_WORDS);
    localparam int BSEL_W      = $clog2(WORD_W);
    localparam int LINK_DEPTH  = MAX_NODES * ROW_WORDS;
    localparam int LINK_AW     = NODE_W + WSEL_W;

    typedef enum logic [2:0] {
        REQ_CLEAR = 3'd0,
        REQ_SET   = 3'd1,
        REQ_LINK  = 3'd2,
        REQ_SWAP  = 3'd3,
        REQ_QUERY = 3'd4
    } req_e;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_SWAP_RD1,
        ST_SWAP_RD2,
        ST_SWAP_WR1,
        ST_SWAP_WR2,
        ST_Q_START,
        ST_Q_EXPAND,
        ST_Q_DRAIN,
        ST_Q_LEVEL,
        ST_Q_MIN,
        ST_Q_MIN_DRAIN,
        ST_Q_OUT
    } state_t;

endpackage

// File: rtl/amr_ram.sv
`timescale 1ns / 1ps
// Single-port synchronous RAM with a registered read port.
// Generic; no package dependency.
module amr_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: rtl/ancestor_min_reachability_unit.sv
`timescale 1ns / 1ps
// Top level of the reachable-ancestor minimum engine: sequencer and both memories.
// Depends on amr_pkg and amr_ram.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, req_type, node_a,     | into block
//           | node_b, value_in                          |
//   out     | out_valid, out_ready, min_value,          | out of block
//           | none_found                                |
//
// One beat is worked at a time through the single port of the link memory.
// Set writes the value memory from idle, add link reads and rewrites one link word, swap exchanges
// rows then columns for distinct nodes, clear sweeps both memories; a query works level by level.
// After reset the link and value memories are swept to zero.
// A finished result waits in the output register while the next beat is taken; a query
// holds its last cycle until that register is free.
module ancestor_min_reachability_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   req_type,
    input  logic [amr_pkg::NODE_W-1:0]   node_a,
    input  logic [amr_pkg::NODE_W-1:0]   node_b,
    input  logic [amr_pkg::VALUE_W-1:0]  value_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [amr_pkg::VALUE_W-1:0]  min_value,
    output logic                         none_found
);

    amr_pkg::state_t state_reg, state_next;

    logic [amr_pkg::LINK_AW-1:0]            cnt_reg;
    logic [amr_pkg::NODE_W-1:0]             a_reg, b_reg, node_reg;
    logic [amr_pkg::WSEL_W-1:0]             word_reg, pend_word_reg;
    logic                                   cols_reg, pend_reg, vpend_reg, found_reg;
    logic [amr_pkg::WORD_W-1:0]             w1_reg, new2_reg;
    logic [amr_pkg::MAX_NODES-1:0]          frontier_reg, reached_reg;
    logic [amr_pkg::ROW_WORDS-1:0][amr_pkg::WORD_W-1:0] next_reg;
    logic [amr_pkg::VALUE_W-1:0]            best_reg, min_reg;
    logic                                   out_valid_reg, none_reg;

    logic                                   link_en, link_we;
    logic [amr_pkg::LINK_AW-1:0]            link_addr;
    logic [amr_pkg::WORD_W-1:0]             link_wdata, link_rdata;
    logic                                   val_en, val_we;
    logic [amr_pkg::NODE_W-1:0]             val_addr;
    logic [amr_pkg::VALUE_W-1:0]            val_wdata, val_rdata;

    logic                                   accept, issue, vissue, last_word, last_node;
    logic [amr_pkg::WSEL_W-1:0]             wsel_a, wsel_b, col_wsel;
    logic [amr_pkg::WORD_W-1:0]             new1, new2, tmp;
    logic                                   bit_a, bit_b;
    logic [amr_pkg::MAX_NODES-1:0]          fresh;

    amr_ram #(.WIDTH(amr_pkg::WORD_W), .DEPTH(amr_pkg::LINK_DEPTH)) u_link_ram (
        .clk   (clk),
        .en    (link_en),
        .we    (link_we),
        .addr  (link_addr),
        .wdata (link_wdata),
        .rdata (link_rdata)
    );

    amr_ram #(.WIDTH(amr_pkg::VALUE_W), .DEPTH(amr_pkg::MAX_NODES)) u_value_ram (
        .clk   (clk),
        .en    (val_en),
        .we    (val_we),
        .addr  (val_addr),
        .wdata (val_wdata),
        .rdata (val_rdata)
    );

    assign in_ready   = (state_reg == amr_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign min_value  = min_reg;
    assign none_found = none_reg;

    assign wsel_a    = a_reg[amr_pkg::NODE_W-1:amr_pkg::BSEL_W];
    assign wsel_b    = b_reg[amr_pkg::NODE_W-1:amr_pkg::BSEL_W];
    assign last_word = (word_reg == amr_pkg::WSEL_W'(amr_pkg::ROW_WORDS - 1));
    assign last_node = (node_reg == amr_pkg::NODE_W'(amr_pkg::MAX_NODES - 1));
    assign fresh     = next_reg & ~reached_reg;
    assign issue     = (state_reg == amr_pkg::ST_Q_START)
                    || ((state_reg == amr_pkg::ST_Q_EXPAND) && frontier_reg[node_reg]);
    assign vissue    = (state_reg == amr_pkg::ST_Q_MIN) && reached_reg[node_reg];
    assign col_wsel  = cols_reg ? wsel_a : word_reg;

    always_comb
    begin
        bit_a = w1_reg[a_reg[amr_pkg::BSEL_W-1:0]];
        bit_b = link_rdata[b_reg[amr_pkg::BSEL_W-1:0]];
        tmp   = w1_reg;
        new1  = link_rdata;
        new2  = w1_reg;
        if (cols_reg)
        begin
            if (wsel_a == wsel_b)
            begin
                tmp[a_reg[amr_pkg::BSEL_W-1:0]] = bit_b;
                tmp[b_reg[amr_pkg::BSEL_W-1:0]] = bit_a;
                new1 = tmp;
                new2 = tmp;
            end
            else
            begin
                new1 = w1_reg;
                new1[a_reg[amr_pkg::BSEL_W-1:0]] = bit_b;
                new2 = link_rdata;
                new2[b_reg[amr_pkg::BSEL_W-1:0]] = bit_a;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amr_pkg::ST_CLEAR:
            begin
                if (cnt_reg == amr_pkg::LINK_AW'(amr_pkg::LINK_DEPTH - 1))
                begin
                    state_next = amr_pkg::ST_IDLE;
                end
            end
            amr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        amr_pkg::REQ_CLEAR: state_next = amr_pkg::ST_CLEAR;
                        amr_pkg::REQ_LINK:  state_next = amr_pkg::ST_LINK_RD;
                        amr_pkg::REQ_SWAP:
                        begin
                            if (node_a != node_b)
                            begin
                                state_next = amr_pkg::ST_SWAP_RD1;
                            end
                        end
                        amr_pkg::REQ_QUERY: state_next = amr_pkg::ST_Q_START;
                        default:            state_next = amr_pkg::ST_IDLE;
                    endcase
                end
            end
            amr_pkg::ST_LINK_RD:  state_next = amr_pkg::ST_LINK_WR;
            amr_pkg::ST_LINK_WR:  state_next = amr_pkg::ST_IDLE;
            amr_pkg::ST_SWAP_RD1: state_next = amr_pkg::ST_SWAP_RD2;
            amr_pkg::ST_SWAP_RD2: state_next = amr_pkg::ST_SWAP_WR1;
            amr_pkg::ST_SWAP_WR1: state_next = amr_pkg::ST_SWAP_WR2;
            amr_pkg::ST_SWAP_WR2:
            begin
                if (cols_reg && last_node)
                begin
                    state_next = amr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = amr_pkg::ST_SWAP_RD1;
                end
            end
            amr_pkg::ST_Q_START:
            begin
                if (last_word)
                begin
                    state_next = amr_pkg::ST_Q_DRAIN;
                end
            end
            amr_pkg::ST_Q_EXPAND:
            begin
                if (last_node && (!frontier_reg[node_reg] || last_word))
                begin
                    state_next = amr_pkg::ST_Q_DRAIN;
                end
            end
            amr_pkg::ST_Q_DRAIN:  state_next = amr_pkg::ST_Q_LEVEL;
            amr_pkg::ST_Q_LEVEL:
            begin
                state_next = (fresh != '0) ? amr_pkg::ST_Q_EXPAND : amr_pkg::ST_Q_MIN;
            end
            amr_pkg::ST_Q_MIN:
            begin
                if (last_node)
                begin
                    state_next = amr_pkg::ST_Q_MIN_DRAIN;
                end
            end
            amr_pkg::ST_Q_MIN_DRAIN: state_next = amr_pkg::ST_Q_OUT;
            amr_pkg::ST_Q_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = amr_pkg::ST_IDLE;
                end
            end
            default: state_next = amr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        link_en    = 1'b0;
        link_we    = 1'b0;
        link_addr  = '0;
        link_wdata = '0;
        val_en     = 1'b0;
        val_we     = 1'b0;
        val_addr   = '0;
        val_wdata  = '0;
        unique case (state_reg)
            amr_pkg::ST_CLEAR:
            begin
                link_en   = 1'b1;
                link_we   = 1'b1;
                link_addr = cnt_reg;
                val_en    = 1'b1;
                val_we    = 1'b1;
                val_addr  = cnt_reg[amr_pkg::NODE_W-1:0];
            end
            amr_pkg::ST_IDLE:
            begin
                if (accept && (req_type == amr_pkg::REQ_SET))
                begin
                    val_en    = 1'b1;
                    val_we    = 1'b1;
                    val_addr  = node_a;
                    val_wdata = value_in;
                end
            end
            amr_pkg::ST_LINK_RD:
            begin
                link_en   = 1'b1;
                link_addr = {b_reg, wsel_a};
            end
            amr_pkg::ST_LINK_WR:
            begin
                link_en    = 1'b1;
                link_we    = 1'b1;
                link_addr  = {b_reg, wsel_a};
                link_wdata = link_rdata;
                link_wdata[a_reg[amr_pkg::BSEL_W-1:0]] = 1'b1;
            end
            amr_pkg::ST_SWAP_RD1:
            begin
                link_en   = 1'b1;
                link_addr = cols_reg ? {node_reg, wsel_a} : {a_reg, word_reg};
            end
            amr_pkg::ST_SWAP_RD2:
            begin
                link_en   = 1'b1;
                link_addr = cols_reg ? {node_reg, wsel_b} : {b_reg, word_reg};
            end
            amr_pkg::ST_SWAP_WR1:
            begin
                link_en    = 1'b1;
                link_we    = 1'b1;
                link_addr  = cols_reg ? {node_reg, wsel_a} : {a_reg, word_reg};
                link_wdata = new1;
            end
            amr_pkg::ST_SWAP_WR2:
            begin
                link_en    = 1'b1;
                link_we    = 1'b1;
                link_addr  = cols_reg ? {node_reg, wsel_b} : {b_reg, word_reg};
                link_wdata = new2_reg;
            end
            amr_pkg::ST_Q_START:
            begin
                link_en   = 1'b1;
                link_addr = {a_reg, word_reg};
            end
            amr_pkg::ST_Q_EXPAND:
            begin
                link_en   = issue;
                link_addr = {node_reg, word_reg};
            end
            amr_pkg::ST_Q_MIN:
            begin
                val_en   = vissue;
                val_addr = node_reg;
            end
            default:
            begin
                link_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amr_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            vpend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            vpend_reg <= vissue;
            if (state_reg == amr_pkg::ST_CLEAR)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if ((state_reg == amr_pkg::ST_Q_OUT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_word_reg <= word_reg;
        if (pend_reg)
        begin
            next_reg[pend_word_reg] <= next_reg[pend_word_reg] | link_rdata;
        end
        if (vpend_reg)
        begin
            found_reg <= 1'b1;
            if (val_rdata < best_reg)
            begin
                best_reg <= val_rdata;
            end
        end
        unique case (state_reg)
            amr_pkg::ST_IDLE:
            begin
                a_reg       <= node_a;
                b_reg       <= node_b;
                word_reg    <= '0;
                node_reg    <= '0;
                cols_reg    <= 1'b0;
                next_reg    <= '0;
                reached_reg <= '0;
            end
            amr_pkg::ST_SWAP_RD2:
            begin
                w1_reg <= link_rdata;
            end
            amr_pkg::ST_SWAP_WR1:
            begin
                new2_reg <= new2;
            end
            amr_pkg::ST_SWAP_WR2:
            begin
                if (!cols_reg)
                begin
                    word_reg <= word_reg + 1'b1;
                    if (last_word)
                    begin
                        cols_reg <= 1'b1;
                        node_reg <= '0;
                    end
                end
                else
                begin
                    node_reg <= node_reg + 1'b1;
                end
            end
            amr_pkg::ST_Q_START:
            begin
                word_reg <= word_reg + 1'b1;
            end
            amr_pkg::ST_Q_EXPAND:
            begin
                if (issue && !last_word)
                begin
                    word_reg <= word_reg + 1'b1;
                end
                else
                begin
                    word_reg <= '0;
                    node_reg <= node_reg + 1'b1;
                end
            end
            amr_pkg::ST_Q_LEVEL:
            begin
                frontier_reg <= fresh;
                reached_reg  <= reached_reg | fresh;
                next_reg     <= '0;
                node_reg     <= '0;
                word_reg     <= '0;
                best_reg     <= '1;
                found_reg    <= 1'b0;
            end
            amr_pkg::ST_Q_MIN:
            begin
                node_reg <= node_reg + 1'b1;
            end
            amr_pkg::ST_Q_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    min_reg  <= found_reg ? best_reg : '0;
                    none_reg <= !found_reg;
                end
            end
            default:
            begin
                w1_reg <= w1_reg;
            end
        endcase
    end

endmodule
